/* design/swo_pkg.sv */
// shared types and constants of the stereo waveform oscillator
`timescale 1ns / 1ps

package swo_pkg;

  // register indexes on the configuration port
  localparam logic [1:0] REG_WAVEFORM = 2'd0;
  localparam logic [1:0] REG_PAN      = 2'd1;
  localparam logic [1:0] REG_VOLUME   = 2'd2;

  localparam int unsigned CFG_ADDR_W = 4;

  // waveform codes
  localparam logic [2:0] WF_SINE     = 3'd0;
  localparam logic [2:0] WF_SAWTOOTH = 3'd1;
  localparam logic [2:0] WF_TRIANGLE = 3'd2;
  localparam logic [2:0] WF_SQUARE   = 3'd3;

  // opcodes
  localparam logic OP_TICK    = 1'b0;
  localparam logic OP_NOTE_ON = 1'b1;

  // shared multiplier operand widths
  localparam int unsigned MUL_A_W = 32;
  localparam int unsigned MUL_B_W = 24;
  localparam int unsigned MUL_P_W = MUL_A_W + MUL_B_W;

  typedef struct packed {
    logic        opcode;
    logic [31:0] phase_step;
    logic [31:0] start_phase;
    logic [6:0]  note_velocity;
    logic [15:0] start_delay;
  } in_item_t;

  typedef struct packed {
    logic signed [15:0] left_sample;
    logic signed [15:0] right_sample;
  } out_item_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_INDEX,
    ST_SAMPLE,
    ST_LEVEL,
    ST_MUL_L,
    ST_RES_L,
    ST_MUL_R,
    ST_RES_R,
    ST_DONE
  } osc_state_t;

  typedef enum logic [2:0] {
    MS_INDEX,
    MS_LEVEL,
    MS_GAIN_L,
    MS_GAIN_R,
    MS_SCALE
  } mul_sel_t;

  typedef struct packed {
    logic     in_ready;
    logic     mul_en;
    mul_sel_t mul_sel;
    logic     ld_sample;
    logic     ld_level;
    logic     ld_left;
    logic     ld_right;
    logic     ld_out;
  } seq_ctrl_t;

  typedef struct packed {
    logic in_valid;
    logic tick_run;
    logic delay_nz;
    logic out_busy;
  } seq_stat_t;

endpackage

/* design/swo_mul.sv */
// shared unsigned multiplier with registered product
`timescale 1ns / 1ps

module swo_mul (
  input  logic                          clk,
  input  logic                          en,
  input  logic [swo_pkg::MUL_A_W-1:0]   a,
  input  logic [swo_pkg::MUL_B_W-1:0]   b,
  output logic [swo_pkg::MUL_P_W-1:0]   prod
);

  logic [swo_pkg::MUL_P_W-1:0] prod_r;
  logic [swo_pkg::MUL_P_W-1:0] prod_nxt;

  assign prod_nxt = {{swo_pkg::MUL_B_W{1'b0}}, a} * {{swo_pkg::MUL_A_W{1'b0}}, b};

  always_ff @(posedge clk) begin
    if (en) begin
      prod_r <= prod_nxt;
    end
  end

  assign prod = prod_r;

endmodule

/* design/swo_seq.sv */
// sequencer that steps one tick through the shared multiplier
`timescale 1ns / 1ps

module swo_seq (
  input  logic               clk,
  input  logic               rst_n,
  input  swo_pkg::seq_stat_t stat,
  output swo_pkg::seq_ctrl_t ctrl
);

  swo_pkg::osc_state_t state_r;
  swo_pkg::osc_state_t state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= swo_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      swo_pkg::ST_IDLE: begin
        if (stat.in_valid && stat.tick_run) begin
          state_nxt = stat.delay_nz ? swo_pkg::ST_DONE : swo_pkg::ST_INDEX;
        end
      end
      swo_pkg::ST_INDEX:  state_nxt = swo_pkg::ST_SAMPLE;
      swo_pkg::ST_SAMPLE: state_nxt = swo_pkg::ST_LEVEL;
      swo_pkg::ST_LEVEL:  state_nxt = swo_pkg::ST_MUL_L;
      swo_pkg::ST_MUL_L:  state_nxt = swo_pkg::ST_RES_L;
      swo_pkg::ST_RES_L:  state_nxt = swo_pkg::ST_MUL_R;
      swo_pkg::ST_MUL_R:  state_nxt = swo_pkg::ST_RES_R;
      swo_pkg::ST_RES_R:  state_nxt = swo_pkg::ST_DONE;
      swo_pkg::ST_DONE: begin
        if (!stat.out_busy) begin
          state_nxt = swo_pkg::ST_IDLE;
        end
      end
      default: state_nxt = swo_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    ctrl           = '0;
    ctrl.mul_sel   = swo_pkg::MS_INDEX;
    unique case (state_r)
      swo_pkg::ST_IDLE: ctrl.in_ready = 1'b1;
      swo_pkg::ST_INDEX: begin
        ctrl.mul_en  = 1'b1;
        ctrl.mul_sel = swo_pkg::MS_INDEX;
      end
      swo_pkg::ST_SAMPLE: begin
        // table index is in the product now; start volume times velocity
        ctrl.ld_sample = 1'b1;
        ctrl.mul_en    = 1'b1;
        ctrl.mul_sel   = swo_pkg::MS_LEVEL;
      end
      swo_pkg::ST_LEVEL: begin
        ctrl.ld_level = 1'b1;
        ctrl.mul_en   = 1'b1;
        ctrl.mul_sel  = swo_pkg::MS_GAIN_L;
      end
      swo_pkg::ST_MUL_L: begin
        ctrl.mul_en  = 1'b1;
        ctrl.mul_sel = swo_pkg::MS_SCALE;
      end
      swo_pkg::ST_RES_L: begin
        ctrl.ld_left = 1'b1;
        ctrl.mul_en  = 1'b1;
        ctrl.mul_sel = swo_pkg::MS_GAIN_R;
      end
      swo_pkg::ST_MUL_R: begin
        ctrl.mul_en  = 1'b1;
        ctrl.mul_sel = swo_pkg::MS_SCALE;
      end
      swo_pkg::ST_RES_R: ctrl.ld_right = 1'b1;
      swo_pkg::ST_DONE:  ctrl.ld_out = !stat.out_busy;
      default: ctrl.in_ready = 1'b0;
    endcase
  end

endmodule

/* design/stereo_waveform_oscillator.sv */
// top level: phase accumulator, waveform shaping, gain stage and register port
//
// Stereo phase-accumulator oscillator. Items arrive on in_valid/in_ready with
// in_data; a note-on item loads step, start phase, velocity and start delay
// and gives no result. A tick item gives no result while no note is active,
// a pair of zero samples while the start delay counts down, and otherwise a
// left/right sample pair on out_valid/out_ready with out_data.
// A note-on or an idle tick is taken in the idle state and the next item can
// follow at once. A tick in the delay loads its zero pair into the result
// register in DONE; a sounding tick steps through INDEX, SAMPLE, LEVEL,
// MUL_L, RES_L, MUL_R, RES_R and DONE. The next item is taken only back in
// idle. The steps follow the single 32x24 multiplier, used six times per
// sounding tick (table index, volume times velocity, and sample times gain
// then times level for each side). The result register lets the next item be
// accepted while a result waits; a tick that reaches its result while the
// previous one is still unread holds in place until out_ready frees the
// register. Waveform, pan and volume are written over the APB-style port;
// the user must write them only while the block is idle, as the block itself
// does not enforce this. Reset (synchronous, rst_n low) clears the note
// state, drops any pending result, sets waveform 0, pan 0 and volume 65535.
`timescale 1ns / 1ps

module stereo_waveform_oscillator #(
  parameter int unsigned PHASE_BITS       = 32,
  parameter int unsigned SINE_TABLE_DEPTH = 256
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  swo_pkg::in_item_t                   in_data,
  output logic                                out_valid,
  input  logic                                out_ready,
  output swo_pkg::out_item_t                  out_data,
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic [swo_pkg::CFG_ADDR_W-1:0]      paddr,
  input  logic [31:0]                         pwdata,
  output logic [31:0]                         prdata,
  output logic                                pready
);

  localparam int unsigned IDX_W = $clog2(SINE_TABLE_DEPTH + 1);

  typedef logic [14:0] rom_t [SINE_TABLE_DEPTH + 1];

  // quarter-wave table, odd polynomial in Q30 evaluated at elaboration
  function automatic rom_t build_rom();
    rom_t        t;
    logic [63:0] x;
    logic [63:0] x2;
    logic [63:0] r;
    int          k;
    for (k = 0; k <= SINE_TABLE_DEPTH; k++) begin
      x  = (64'(k) << 30) / 64'(SINE_TABLE_DEPTH);
      x2 = (x * x) >> 30;
      r  = 64'd3864;
      r  = 64'd172272 - ((r * x2) >> 30);
      r  = 64'd5026995 - ((r * x2) >> 30);
      r  = 64'd85569306 - ((r * x2) >> 30);
      r  = 64'd693598668 - ((r * x2) >> 30);
      r  = 64'd1686629713 - ((r * x2) >> 30);
      r  = (r * x) >> 30;
      r  = (r + 64'd16384) >> 15;
      if (r > 64'd32767) begin
        r = 64'd32767;
      end
      t[k] = r[14:0];
    end
    return t;
  endfunction

  localparam rom_t SINE_ROM = build_rom();

  function automatic logic signed [15:0] sat_out(input logic [18:0] mag, input logic neg);
    logic [15:0] low;
    low = mag[15:0];
    if (neg) begin
      return (mag > 19'd32768) ? 16'sh8000 : signed'(16'(~low + 16'd1));
    end
    return (mag > 19'd32767) ? 16'sh7fff : signed'(low);
  endfunction

  swo_pkg::seq_ctrl_t ctrl;
  swo_pkg::seq_stat_t stat;

  // configuration
  logic [2:0]         wave_r;
  logic signed [15:0] pan_r;
  logic [15:0]        vol_r;
  logic               cfg_wr;

  // note state
  logic                  active_r;
  logic [PHASE_BITS-1:0] phase_r;
  logic [PHASE_BITS-1:0] step_r;
  logic [15:0]           delay_r;
  logic [6:0]            vel_r;

  logic [PHASE_BITS-1:0] step_in;
  logic [PHASE_BITS-1:0] phase_in;
  logic [31:0]           u;

  // working registers
  logic signed [15:0] sample_r;
  logic signed [15:0] sample_nxt;
  logic [23:0]        level_r;
  logic signed [15:0] left_r;
  logic signed [15:0] right_r;

  logic                          out_valid_r;
  swo_pkg::out_item_t            out_data_r;

  logic [swo_pkg::MUL_A_W-1:0] mul_a;
  logic [swo_pkg::MUL_B_W-1:0] mul_b;
  logic [swo_pkg::MUL_P_W-1:0] mul_p;

  logic               in_fire;
  logic               tick_fire;
  logic signed [16:0] gain_l;
  logic signed [16:0] gain_r;
  logic [15:0]        gain_l_mag;
  logic [15:0]        gain_r_mag;
  logic [15:0]        s_mag;
  logic signed [16:0] s_wide;
  logic               neg_l;
  logic               neg_r;
  logic [56:0]        rnd_sum;
  logic [18:0]        rnd_mag;

  logic [IDX_W-1:0]   rom_idx;
  logic [IDX_W-1:0]   rom_addr;
  logic [14:0]        rom_val;
  logic signed [17:0] tri_v;
  logic [31:0]        tri_d;

  // phase scaling between the 32-bit host phases and the accumulator
  if (PHASE_BITS >= 32) begin : g_wide_phase
    assign step_in  = PHASE_BITS'(in_data.phase_step) << (PHASE_BITS - 32);
    assign phase_in = PHASE_BITS'(in_data.start_phase) << (PHASE_BITS - 32);
    assign u        = phase_r[PHASE_BITS-1 -: 32];
  end else begin : g_narrow_phase
    assign step_in  = PHASE_BITS'(in_data.phase_step >> (32 - PHASE_BITS));
    assign phase_in = PHASE_BITS'(in_data.start_phase >> (32 - PHASE_BITS));
    assign u        = 32'(phase_r) << (32 - PHASE_BITS);
  end

  assign in_ready  = ctrl.in_ready;
  assign in_fire   = in_valid && in_ready;
  assign tick_fire = in_fire && (in_data.opcode == swo_pkg::OP_TICK) && active_r;

  assign stat.in_valid = in_valid;
  assign stat.tick_run = (in_data.opcode == swo_pkg::OP_TICK) && active_r;
  assign stat.delay_nz = (delay_r != 16'd0);
  assign stat.out_busy = out_valid_r && !out_ready;

  swo_seq u_seq (
    .clk   (clk),
    .rst_n (rst_n),
    .stat  (stat),
    .ctrl  (ctrl)
  );

  // register port
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;

  always_comb begin
    unique case (paddr[3:2])
      swo_pkg::REG_WAVEFORM: prdata = {29'd0, wave_r};
      swo_pkg::REG_PAN:      prdata = {16'd0, pan_r};
      swo_pkg::REG_VOLUME:   prdata = {16'd0, vol_r};
      default:               prdata = 32'd0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wave_r <= 3'd0;
      pan_r  <= 16'sd0;
      vol_r  <= 16'hffff;
    end else if (cfg_wr) begin
      unique case (paddr[3:2])
        swo_pkg::REG_WAVEFORM: wave_r <= pwdata[2:0];
        swo_pkg::REG_PAN:      pan_r  <= signed'(pwdata[15:0]);
        swo_pkg::REG_VOLUME:   vol_r  <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  // note state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_r <= 1'b0;
      phase_r  <= '0;
      step_r   <= '0;
      delay_r  <= 16'd0;
      vel_r    <= 7'd0;
    end else if (in_fire && (in_data.opcode == swo_pkg::OP_NOTE_ON)) begin
      active_r <= 1'b1;
      phase_r  <= phase_in;
      step_r   <= step_in;
      delay_r  <= in_data.start_delay;
      vel_r    <= in_data.note_velocity;
    end else if (tick_fire) begin
      if (delay_r != 16'd0) begin
        delay_r <= delay_r - 16'd1;
      end else begin
        phase_r <= phase_r + step_r;
      end
    end
  end

  // waveform shaping; the sine table index comes from the multiplier
  assign rom_idx  = mul_p[32 +: IDX_W];
  assign rom_addr = u[30] ? (IDX_W'(SINE_TABLE_DEPTH) - rom_idx) : rom_idx;
  assign rom_val  = SINE_ROM[rom_addr];
  assign tri_d    = u - 32'h8000_0000;

  always_comb begin
    if (u <= 32'h8000_0000) begin
      tri_v = signed'({1'b0, u[31:15]}) - 18'sd32768;
    end else begin
      tri_v = 18'sd32768 - signed'({1'b0, tri_d[31:15]});
    end
    if (tri_v > 18'sd32767) begin
      tri_v = 18'sd32767;
    end else if (tri_v < -18'sd32768) begin
      tri_v = -18'sd32768;
    end
  end

  always_comb begin
    unique case (wave_r)
      swo_pkg::WF_SINE: begin
        sample_nxt = u[31] ? -signed'({1'b0, rom_val}) : signed'({1'b0, rom_val});
      end
      swo_pkg::WF_SAWTOOTH: sample_nxt = signed'({~u[31], u[30:16]});
      swo_pkg::WF_TRIANGLE: sample_nxt = 16'(tri_v);
      swo_pkg::WF_SQUARE:   sample_nxt = (u > 32'h8000_0000) ? 16'sh7fff : 16'sh8000;
      default:              sample_nxt = 16'sd0;
    endcase
  end

  // magnitudes and signs for the gain stage
  assign s_wide     = 17'(sample_r);
  assign s_mag      = sample_r[15] ? 16'(-s_wide) : 16'(s_wide);
  assign gain_l     = 17'(pan_r) + 17'sd16384;
  assign gain_r     = 17'sd16384 - 17'(pan_r);
  assign gain_l_mag = gain_l[16] ? 16'(-gain_l) : 16'(gain_l);
  assign gain_r_mag = gain_r[16] ? 16'(-gain_r) : 16'(gain_r);
  assign neg_l      = sample_r[15] ^ gain_l[16];
  assign neg_r      = sample_r[15] ^ gain_r[16];

  always_comb begin
    unique case (ctrl.mul_sel)
      swo_pkg::MS_INDEX: begin
        mul_a = {u[29:0], 2'b00};
        mul_b = swo_pkg::MUL_B_W'(SINE_TABLE_DEPTH);
      end
      swo_pkg::MS_LEVEL: begin
        mul_a = 32'(vol_r);
        mul_b = 24'(vel_r);
      end
      swo_pkg::MS_GAIN_L: begin
        mul_a = 32'(s_mag);
        mul_b = 24'(gain_l_mag);
      end
      swo_pkg::MS_GAIN_R: begin
        mul_a = 32'(s_mag);
        mul_b = 24'(gain_r_mag);
      end
      swo_pkg::MS_SCALE: begin
        mul_a = mul_p[31:0];
        mul_b = level_r;
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  swo_mul u_mul (
    .clk  (clk),
    .en   (ctrl.mul_en),
    .a    (mul_a),
    .b    (mul_b),
    .prod (mul_p)
  );

  // round half away from zero: magnitude plus half, drop 38 fraction bits
  assign rnd_sum = {1'b0, mul_p} + (57'd1 << 37);
  assign rnd_mag = rnd_sum[56:38];

  always_ff @(posedge clk) begin
    if (ctrl.ld_sample) begin
      sample_r <= sample_nxt;
    end
    if (ctrl.ld_level) begin
      level_r <= mul_p[23:0];
    end
    if (tick_fire && (delay_r != 16'd0)) begin
      left_r  <= 16'sd0;
      right_r <= 16'sd0;
    end else begin
      if (ctrl.ld_left) begin
        left_r <= sat_out(rnd_mag, neg_l);
      end
      if (ctrl.ld_right) begin
        right_r <= sat_out(rnd_mag, neg_r);
      end
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (ctrl.ld_out) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.ld_out) begin
      out_data_r.left_sample  <= left_r;
      out_data_r.right_sample <= right_r;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

/* tb/sv/stereo_waveform_oscillator_tb.sv */
// testbench of the stereo waveform oscillator: directed and random items against a predictor
`timescale 1ns / 1ps

module stereo_waveform_oscillator_tb;

  localparam int SINE_DEPTH = 256;
  localparam logic [1:0] REG_UNUSED = 2'd3;

  class osc_scoreboard;
    int rom [0:SINE_DEPTH];
    logic [2:0] waveform;
    logic signed [15:0] pan;
    logic [15:0] volume;
    bit active;
    bit [31:0] phase;
    bit [31:0] step;
    bit [15:0] delay_left;
    bit [6:0] velocity;
    swo_pkg::out_item_t pending_q[$];
    int fails, notes, ticks, checked;

    function new();
      longint unsigned x, x2, r;
      for (int k = 0; k <= SINE_DEPTH; k++) begin
        // odd polynomial for sin(pi/2 * x), coefficients in Q30
        x = (64'(k) << 30) / SINE_DEPTH;
        x2 = (x * x) >> 30;
        r = 3864;
        r = 172272 - ((r * x2) >> 30);
        r = 5026995 - ((r * x2) >> 30);
        r = 85569306 - ((r * x2) >> 30);
        r = 693598668 - ((r * x2) >> 30);
        r = 1686629713 - ((r * x2) >> 30);
        r = (r * x) >> 30;
        r = (r + 16384) >> 15;
        rom[k] = (r > 32767) ? 32767 : int'(r);
      end
      waveform = swo_pkg::WF_SINE;
      pan = '0;
      volume = 16'hFFFF;
      active = 1'b0;
      phase = '0;
      step = '0;
      delay_left = '0;
      velocity = '0;
      fails = 0;
      notes = 0;
      ticks = 0;
      checked = 0;
    endfunction

    function longint sat16(longint v);
      if (v > 32767) return 32767;
      if (v < -32768) return -32768;
      return v;
    endfunction

    function longint shape(bit [31:0] u);
      bit [31:0] f;
      int idx;
      longint v;
      case (waveform)
        swo_pkg::WF_SINE: begin
          f = {u[29:0], 2'b00};
          idx = int'((64'(f) * SINE_DEPTH) >> 32);
          if (idx > SINE_DEPTH) idx = SINE_DEPTH;
          v = u[30] ? rom[SINE_DEPTH - idx] : rom[idx];
          return u[31] ? -v : v;
        end
        swo_pkg::WF_SAWTOOTH: return longint'({32'd0, u >> 16}) - 32768;
        swo_pkg::WF_TRIANGLE: begin
          if (u <= 32'h8000_0000) return sat16(longint'({32'd0, u >> 15}) - 32768);
          return sat16(32768 - longint'({32'd0, (u - 32'h8000_0000) >> 15}));
        end
        swo_pkg::WF_SQUARE: return (u > 32'h8000_0000) ? 32767 : -32768;
        default: return 0;
      endcase
    endfunction

    // sample * gain * volume * velocity is Q53, rounded away from zero to Q1.15
    function logic signed [15:0] level(longint s, longint gain);
      longint prod;
      bit neg;
      longint unsigned m;
      prod = s * gain;
      neg = prod < 0;
      m = neg ? -prod : prod;
      m = m * 64'(volume) * 64'(velocity);
      m = (m + (64'd1 << 37)) >> 38;
      if (neg) return (m > 32768) ? 16'sh8000 : 16'(-longint'(m));
      return (m > 32767) ? 16'sh7FFF : 16'(m);
    endfunction

    function void set_reg(logic [1:0] idx, logic [31:0] val);
      case (idx)
        swo_pkg::REG_WAVEFORM: waveform = val[2:0];
        swo_pkg::REG_PAN:      pan = val[15:0];
        swo_pkg::REG_VOLUME:   volume = val[15:0];
        default: ;
      endcase
    endfunction

    function void note_input(swo_pkg::in_item_t it);
      swo_pkg::out_item_t r;
      longint s;
      if (it.opcode == swo_pkg::OP_NOTE_ON) begin
        step = it.phase_step;
        phase = it.start_phase;
        velocity = it.note_velocity;
        delay_left = it.start_delay;
        active = 1'b1;
        notes++;
        return;
      end
      ticks++;
      if (!active) return;
      if (delay_left != 0) begin
        delay_left--;
        r = '0;
      end else begin
        phase = phase + step;
        s = shape(phase);
        r.left_sample = level(s, longint'(pan) + 16384);
        r.right_sample = level(s, 16384 - longint'(pan));
      end
      pending_q.push_back(r);
    endfunction

    function void check_result(swo_pkg::out_item_t got);
      swo_pkg::out_item_t want;
      if (pending_q.size() == 0) begin
        $error("sample pair with none expected: left %0d right %0d",
               got.left_sample, got.right_sample);
        fails++;
        return;
      end
      want = pending_q.pop_front();
      checked++;
      if (got.left_sample !== want.left_sample) begin
        $error("left_sample: expected %0d, got %0d", want.left_sample, got.left_sample);
        fails++;
      end
      if (got.right_sample !== want.right_sample) begin
        $error("right_sample: expected %0d, got %0d", want.right_sample, got.right_sample);
        fails++;
      end
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst_n;
  logic in_valid;
  logic in_ready;
  swo_pkg::in_item_t in_data;
  logic out_valid;
  logic out_ready = 1'b0;
  swo_pkg::out_item_t out_data;
  logic psel;
  logic penable;
  logic pwrite;
  logic [swo_pkg::CFG_ADDR_W-1:0] paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic pready;

  osc_scoreboard sb;
  bit calm;
  int sent;
  int settings;

  stereo_waveform_oscillator DUT (
    .clk(clk),
    .rst_n(rst_n),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .in_data(in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data(out_data),
    .psel(psel),
    .penable(penable),
    .pwrite(pwrite),
    .paddr(paddr),
    .pwdata(pwdata),
    .prdata(prdata),
    .pready(pready)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(negedge clk) begin
    out_ready <= calm || ($urandom_range(99) >= 18);
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && in_ready) sb.note_input(in_data);
      if (out_valid && out_ready) sb.check_result(out_data);
    end
  end

  function automatic swo_pkg::in_item_t mk_tick();
    swo_pkg::in_item_t it;
    it.opcode = swo_pkg::OP_TICK;
    it.phase_step = $urandom;
    it.start_phase = $urandom;
    it.note_velocity = 7'($urandom_range(127));
    it.start_delay = 16'($urandom_range(65535));
    return it;
  endfunction

  function automatic swo_pkg::in_item_t mk_note(logic [31:0] stp, logic [31:0] start,
                                                logic [6:0] vel, logic [15:0] dly);
    swo_pkg::in_item_t it;
    it.opcode = swo_pkg::OP_NOTE_ON;
    it.phase_step = stp;
    it.start_phase = start;
    it.note_velocity = vel;
    it.start_delay = dly;
    return it;
  endfunction

  function automatic swo_pkg::in_item_t rand_note();
    logic [31:0] stp;
    logic [15:0] dly;
    logic [6:0] vel;
    int roll;
    case ($urandom_range(3))
      0: stp = $urandom;
      1: stp = $urandom_range(32'h00FF_FFFF);
      2: stp = $urandom_range(1023);
      default: stp = 32'hFFFF_FFFF - $urandom_range(1023);
    endcase
    roll = $urandom_range(9);
    // long delays are cut short by the next note
    if (roll < 6) dly = '0;
    else if (roll < 9) dly = 16'($urandom_range(1, 4));
    else dly = 16'($urandom_range(65535));
    vel = ($urandom_range(3) == 0) ? 7'd127 : 7'($urandom_range(127));
    return mk_note(stp, $urandom, vel, dly);
  endfunction

  task automatic send_item(swo_pkg::in_item_t it);
    @(negedge clk);
    while (!calm && $urandom_range(99) < 18) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data <= it;
    sent++;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  task automatic write_reg(logic [1:0] idx, logic [31:0] val);
    @(negedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= val;
    @(negedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    sb.set_reg(idx, val);
    @(negedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
  endtask

  // hold the input until every expected pair is out, then let the pipeline drain
  task automatic settle();
    @(negedge clk);
    in_valid <= 1'b0;
    while (sb.pending_q.size() != 0) @(posedge clk);
    repeat (16) @(posedge clk);
  endtask

  initial begin
    logic signed [15:0] pan_pick [6];
    logic [2:0] wf;
    logic [15:0] pv;
    logic [15:0] vol;
    int mark;
    int roll;
    sb = new();
    pan_pick = '{-16'sd16384, 16'sd16384, 16'sd0, -16'sd32768, 16'sd32767, 16'sd8192};
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_data = '0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    calm = 1'b0;
    sent = 0;
    settings = 1;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // directed items at the reset register values
    send_item(mk_tick());
    send_item({swo_pkg::OP_TICK, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 7'h7F, 16'hFFFF});
    send_item(mk_note(32'h4000_0000, 32'h0, 7'd127, 16'd2));
    repeat (5) send_item(mk_tick());
    send_item(mk_note(32'hFFFF_FFFF, 32'hFFFF_FFFF, 7'd0, 16'd0));
    repeat (2) send_item(mk_tick());
    send_item(mk_note(32'h1, 32'h7FFF_FFFF, 7'd1, 16'd0));
    repeat (2) send_item(mk_tick());
    send_item(mk_note(32'h0, 32'h0, 7'd127, 16'hFFFF));
    repeat (2) send_item(mk_tick());
    send_item(mk_note(32'h1234_5678, 32'hA5A5_A5A5, 7'd64, 16'd1));
    repeat (4) send_item(mk_tick());

    for (int p = 0; p < 16; p++) begin
      wf = (p < 8) ? 3'(p) : 3'($urandom_range(7));
      if (p < 6) pv = pan_pick[p];
      else if ($urandom_range(3) == 0) pv = 16'($urandom_range(65535));
      else pv = 16'($urandom_range(32768) - 16384);
      case (p % 4)
        0: vol = 16'hFFFF;
        1: vol = 16'h0000;
        default: vol = 16'($urandom_range(65535));
      endcase
      settle();
      write_reg(swo_pkg::REG_WAVEFORM, {29'd0, wf});
      write_reg(swo_pkg::REG_PAN, {16'd0, pv});
      write_reg(swo_pkg::REG_VOLUME, {16'd0, vol});
      if (p == 2) write_reg(REG_UNUSED, $urandom);
      settings++;
      calm = (p == 5);
      mark = sent;
      // quadrant edges, then one step either side of half a cycle
      send_item(mk_note(32'h4000_0000, 32'h4000_0000, 7'd127, 16'd0));
      repeat (5) send_item(mk_tick());
      send_item(mk_note(32'h1, 32'h7FFF_FFFE, 7'd127, 16'd0));
      repeat (3) send_item(mk_tick());
      while (sent - mark < 80) begin
        roll = $urandom_range(99);
        if (roll < 85) begin
          send_item(rand_note());
          repeat ($urandom_range(1, 16)) send_item(mk_tick());
        end else if (roll < 93) begin
          send_item(rand_note());
        end else begin
          repeat ($urandom_range(1, 4)) send_item(mk_tick());
        end
      end
    end
    calm = 1'b0;
    settle();

    $display("run: %0d note-on and %0d tick items under %0d register settings",
             sb.notes, sb.ticks, settings);
    $display("run: %0d sample pairs compared, all waveform codes and pan extremes used",
             sb.checked);
    if (sb.pending_q.size() != 0) begin
      $error("%0d sample pairs never arrived", sb.pending_q.size());
      sb.fails++;
    end
    if (sb.fails == 0) begin
      $display("stereo_waveform_oscillator_tb passed");
    end else begin
      $display("stereo_waveform_oscillator_tb failed");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("timeout waiting for the block");
    $display("stereo_waveform_oscillator_tb failed");
    $finish;
  end

endmodule
